/* hw/rtl/rca_pkg.sv */
// Shared types and fixed constants for the radial chromatic aberration block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int MIN_WIDTH    = 16;
  localparam int WIDTH_RESET  = 1920;
  localparam int HEIGHT_RESET = 1080;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rca_pixel_t;

endpackage

`default_nettype wire

/* hw/rtl/rca_cell.sv */
// One cell of the pixel window chain: holds a pixel, passes it on when a new
// pixel enters, and drives its channels onto the pick bus when selected.
// Depends on rca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rca_cell
  import rca_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int OFS_W = 4
) (
  input  logic             clk,
  input  logic             shift_en,
  input  rca_pixel_t       pix_in,
  input  logic [OFS_W-1:0] sel_red,
  input  logic [OFS_W-1:0] sel_green,
  input  logic [OFS_W-1:0] sel_blue,
  output rca_pixel_t       pix_out,
  output rca_pixel_t       pick
);

  localparam logic [OFS_W-1:0] MY_OFS = OFS_W'(IDX);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_out <= pix_in;
    end
  end

  // drive zero when not selected so the top can OR all cells together
  always_comb begin
    pick.red   = (sel_red == MY_OFS) ? pix_out.red : '0;
    pick.green = (sel_green == MY_OFS) ? pix_out.green : '0;
    pick.blue  = (sel_blue == MY_OFS) ? pix_out.blue : '0;
  end

endmodule

`default_nettype wire

/* hw/rtl/rca_shift_calc.sv */
// Five-stage pipeline giving the exact channel shift floor(MAX_SHIFT*min(d,1))
// for one pixel position from the elliptical radial distance.
// Depends on rca_pkg only through the shared import convention.
`timescale 1ns / 1ps
`default_nettype none

module rca_shift_calc
  import rca_pkg::*;
#(
  parameter int MAX_SHIFT = 4,
  parameter int MAX_DIM   = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req,
  input  logic [$clog2(MAX_DIM)-1:0]       x,
  input  logic [$clog2(MAX_DIM)-1:0]       y,
  input  logic [$clog2(MAX_DIM+1)-1:0]     width,
  input  logic [$clog2(MAX_DIM+1)-1:0]     height,
  output logic                             done,
  output logic [$clog2(MAX_SHIFT+1)-1:0]   shift
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int SH_W  = $clog2(MAX_SHIFT + 1);
  localparam int A_W   = DIM_W + 1;
  localparam int P_W   = 2 * DIM_W;
  localparam int Q_W   = 4 * DIM_W;
  localparam int CMP_W = 4 * DIM_W + 1 + SH_W;

  // stage 1 inputs
  logic [A_W-1:0]   tx, ty, ew, eh, abs_a, abs_b;
  logic             clip_a, clip_b;

  logic             s1_valid, s2_valid, s3_valid, s4_valid;
  logic             s1_clip, s2_clip, s3_clip, s4_clip;
  logic [DIM_W-1:0] s1_a, s1_b, s1_w, s1_h;
  logic [P_W-1:0]   s2_p, s2_q, s2_r;
  logic [Q_W-1:0]   s3_pp, s3_qq, s3_rr;
  logic [Q_W:0]     s4_num;
  logic [Q_W-1:0]   s4_den;
  logic [CMP_W-1:0] lim;
  logic [SH_W-1:0]  s_calc;

  always_comb begin
    tx     = A_W'({x, 1'b0});
    ty     = A_W'({y, 1'b0});
    ew     = A_W'(width);
    eh     = A_W'(height);
    abs_a  = (tx >= ew) ? tx - ew : ew - tx;
    abs_b  = (ty >= eh) ? ty - eh : eh - ty;
    // a term above one already caps the distance
    clip_a = abs_a > ew;
    clip_b = abs_b > eh;
  end

  always_comb begin
    lim    = CMP_W'(MAX_SHIFT) * CMP_W'(s4_num);
    s_calc = '0;
    for (int k = 1; k <= MAX_SHIFT; k++) begin
      if (CMP_W'(k) * CMP_W'(s4_den) <= lim) begin
        s_calc = SH_W'(k);
      end
    end
    if (s4_clip) begin
      s_calc = SH_W'(MAX_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= req;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_clip <= clip_a || clip_b;
    s1_a    <= abs_a[DIM_W-1:0];
    s1_b    <= abs_b[DIM_W-1:0];
    s1_w    <= width;
    s1_h    <= height;

    s2_clip <= s1_clip;
    s2_p    <= P_W'(s1_a) * P_W'(s1_h);
    s2_q    <= P_W'(s1_b) * P_W'(s1_w);
    s2_r    <= P_W'(s1_w) * P_W'(s1_h);

    s3_clip <= s2_clip;
    s3_pp   <= Q_W'(s2_p) * Q_W'(s2_p);
    s3_qq   <= Q_W'(s2_q) * Q_W'(s2_q);
    s3_rr   <= Q_W'(s2_r) * Q_W'(s2_r);

    s4_clip <= s3_clip;
    s4_num  <= (Q_W+1)'(s3_pp) + (Q_W+1)'(s3_qq);
    s4_den  <= s3_rr;

    shift   <= s_calc;
  end

endmodule

`default_nettype wire

/* hw/rtl/radial_chromatic_aberration.sv */
// Top level of the radial chromatic aberration filter: position counters,
// request sequencer, pixel window chain and output register.
// Depends on rca_pkg, rca_cell and rca_shift_calc.
//
// Channel  Role    Handshake             Payload
// in       sink    in_valid / in_stall   in_blue, in_green, in_red
// out      source  out_valid / out_stall out_blue, out_green, out_red, last_of_run, frame_done
// cfg      sink    cfg_write             cfg_index, cfg_data
//
// A pixel that completes no output leaves the input free; one that completes n outputs
// keeps in_stall high until the last of them is loaded (n = 1 inside a row, MAX_SHIFT+1 at row end).
// Each output takes an issue step, the five-stage shift pipeline and a load step.
// Reset clears counters and handshake state; width and height return to
// 1920 and 1080, capped at MAX_DIM.
// out_stall holds the output register and the sequencer waits in its load step.
`timescale 1ns / 1ps
`default_nettype none

module radial_chromatic_aberration
  import rca_pkg::*;
#(
  parameter int MAX_SHIFT = 4,
  parameter int MAX_DIM   = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_blue,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_red,
  output logic                 last_of_run,
  output logic                 frame_done
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int SH_W    = $clog2(MAX_SHIFT + 1);
  localparam int DEPTH   = 2 * MAX_SHIFT + 1;
  localparam int OFS_W   = $clog2(DEPTH);
  localparam int EXT_W   = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int W_RESET = (WIDTH_RESET > MAX_DIM) ? MAX_DIM : WIDTH_RESET;
  localparam int H_RESET = (HEIGHT_RESET > MAX_DIM) ? MAX_DIM : HEIGHT_RESET;

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_EMIT} state_t;

  state_t           state;
  logic [DIM_W-1:0] width_eff, height_eff, width_clamp, height_clamp;
  logic [EXT_W-1:0] cfg_ext;
  logic [POS_W-1:0] column_count, row_count;
  logic [POS_W-1:0] cur_x, cur_c, cur_end, cur_row;
  logic             frame_end, issue;
  logic [SH_W-1:0]  s_hold, s_value;
  logic             s_done;
  logic             in_accept, out_free, row_end, frame_hit, last_pick;
  logic [DIM_W-1:0] col_plus, row_plus;
  logic [POS_W-1:0] gap_full;
  logic [OFS_W-1:0] gap, s_ofs, sel_red, sel_green, sel_blue;
  rca_pixel_t       pix_new, picked;
  rca_pixel_t       window [DEPTH];
  rca_pixel_t       picks [DEPTH];

  // clamp register writes to the legal range as they arrive
  assign cfg_ext = EXT_W'(cfg_data);

  always_comb begin
    if (cfg_ext < EXT_W'(MIN_WIDTH)) begin
      width_clamp = DIM_W'(MIN_WIDTH);
    end else if (cfg_ext > EXT_W'(MAX_DIM)) begin
      width_clamp = DIM_W'(MAX_DIM);
    end else begin
      width_clamp = cfg_ext[DIM_W-1:0];
    end
    if (cfg_ext == '0) begin
      height_clamp = DIM_W'(1);
    end else if (cfg_ext > EXT_W'(MAX_DIM)) begin
      height_clamp = DIM_W'(MAX_DIM);
    end else begin
      height_clamp = cfg_ext[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= DIM_W'(W_RESET);
      height_eff <= DIM_W'(H_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_eff  <= width_clamp;
        REG_IMAGE_HEIGHT: height_eff <= height_clamp;
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign col_plus  = DIM_W'(column_count) + DIM_W'(1);
  assign row_plus  = DIM_W'(row_count) + DIM_W'(1);
  assign row_end   = col_plus >= width_eff;
  assign frame_hit = row_plus >= height_eff;
  assign last_pick = (cur_x == cur_end);

  // window offsets counted back from the newest pixel (column cur_c)
  assign gap_full  = cur_c - cur_x;
  assign gap       = gap_full[OFS_W-1:0];
  assign s_ofs     = OFS_W'(s_hold);
  assign sel_green = gap;
  assign sel_red   = (gap > s_ofs) ? gap - s_ofs : '0;
  assign sel_blue  = (cur_x >= POS_W'(s_hold)) ? gap + s_ofs : cur_c[OFS_W-1:0];

  always_comb begin
    pix_new.red   = in_red;
    pix_new.green = in_green;
    pix_new.blue  = in_blue;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rca_pixel_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = pix_new;
    end else begin : g_link
      assign cell_in = window[i-1];
    end
    rca_cell #(
      .IDX   (i),
      .OFS_W (OFS_W)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_accept),
      .pix_in    (cell_in),
      .sel_red   (sel_red),
      .sel_green (sel_green),
      .sel_blue  (sel_blue),
      .pix_out   (window[i]),
      .pick      (picks[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | picks[i];
    end
  end

  rca_shift_calc #(
    .MAX_SHIFT (MAX_SHIFT),
    .MAX_DIM   (MAX_DIM)
  ) u_shift (
    .clk    (clk),
    .rst    (rst),
    .req    (issue),
    .x      (cur_x),
    .y      (cur_row),
    .width  (width_eff),
    .height (height_eff),
    .done   (s_done),
    .shift  (s_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      issue        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      issue <= 1'b0;
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            cur_c   <= column_count;
            cur_row <= row_count;
            cur_x   <= column_count - POS_W'(MAX_SHIFT);
            if (row_end) begin
              // flush the rest of the row from this pixel
              column_count <= '0;
              row_count    <= frame_hit ? '0 : row_count + POS_W'(1);
              cur_end      <= column_count;
              frame_end    <= frame_hit;
              issue        <= 1'b1;
              state        <= ST_WAIT;
            end else begin
              column_count <= column_count + POS_W'(1);
              cur_end      <= column_count - POS_W'(MAX_SHIFT);
              frame_end    <= 1'b0;
              if (column_count >= POS_W'(MAX_SHIFT)) begin
                issue <= 1'b1;
                state <= ST_WAIT;
              end
            end
          end
        end
        ST_WAIT: begin
          if (s_done) begin
            s_hold <= s_value;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_red     <= picked.red;
            out_green   <= picked.green;
            out_blue    <= picked.blue;
            last_of_run <= last_pick;
            frame_done  <= last_pick && frame_end;
            if (last_pick) begin
              state <= ST_IDLE;
            end else begin
              cur_x <= cur_x + POS_W'(1);
              issue <= 1'b1;
              state <= ST_WAIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rca_checker.sv */
// Port-level checks for the radial chromatic aberration top level, attached
// by the bind below. Depends on rca_pkg and radial_chromatic_aberration.
`timescale 1ns / 1ps
`default_nettype none

module rca_checker
  import rca_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_blue,
  input logic [PIX_W-1:0] out_green,
  input logic [PIX_W-1:0] out_red,
  input logic             last_of_run,
  input logic             frame_done
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request left valid after reset");

  a_frame_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> last_of_run)
    else $error("frame end flagged on a request that does not close its run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_green)
                                  && $stable(out_blue) && $stable(last_of_run)
                                  && $stable(frame_done)))
    else $error("stalled output request changed");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("output request appeared one cycle after an input request");

endmodule

bind radial_chromatic_aberration rca_checker u_rca_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for radial_chromatic_aberration: drives raster pixels, predicts
// the channel-shifted output stream and compares every output request field by field.
// Depends on rca_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import rca_pkg::*;

  localparam int MAX_SHIFT     = 4;
  localparam int MAX_DIM       = 4096;
  localparam int WIN_DEPTH     = 2 * MAX_SHIFT + 1;
  localparam int TOTAL_PIXELS  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_SLACK   = 16;
  localparam int LIMIT_NS      = 4_000_000;

  typedef enum bit {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    rca_pixel_t           pix;
    int                   exp_n;
  } stim_row_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
    logic             done;
  } shifted_px_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_blue;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_red;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_red;
  logic             last_of_run;
  logic             frame_done;

  // Predictor state
  logic [CFG_W-1:0] width_reg  = CFG_W'(WIDTH_RESET);
  logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
  int               col_pos    = 0;
  int               row_pos    = 0;
  rca_pixel_t       line_win [WIN_DEPTH];
  shifted_px_t      shifted_due [$];

  int pixels_sent    = 0;
  int results_seen   = 0;
  int rows_ended     = 0;
  int frames_ended   = 0;
  int fault_count    = 0;
  bit in_steady      = 1'b0;
  bit out_steady     = 1'b0;
  bit hold_out       = 1'b0;

  // Short directed pass: minimum geometry first, then the largest
  stim_row_t directed_rows [26] = '{
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'd0,    24'h000000, -1},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'd0,    24'h000000, -1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFF0000, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h0000FF, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h808080, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h7F7F7F, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h010203, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFEFDFC, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hAA55AA, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h55AA55, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h0F0F0F, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hF0F0F0, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h123456, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, MAX_SHIFT + 1},
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'd8191, 24'h000000, -1},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'd8191, 24'h000000, -1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFF00FF, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00FFFF, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h102030, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hC0FFEE, 0},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 1},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFF00, 1}
  };

  radial_chromatic_aberration #(
    .MAX_SHIFT (MAX_SHIFT),
    .MAX_DIM   (MAX_DIM)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_blue     (in_blue),
    .in_green    (in_green),
    .in_red      (in_red),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lo);
    int d;
    d = int'(v);
    if (d < lo) d = lo;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // Exact floor(MAX_SHIFT * min(d, 1)) with d = num / den
  function automatic int radial_shift(input int x, input int y, input int w, input int h);
    longint          a, b;
    longint unsigned w2, h2, num, den, lim;
    int              s;
    a   = 2 * longint'(x) - longint'(w);
    b   = 2 * longint'(y) - longint'(h);
    w2  = longint'(w) * longint'(w);
    h2  = longint'(h) * longint'(h);
    num = longint'(a * a) * h2 + longint'(b * b) * w2;
    den = w2 * h2;
    lim = longint'(MAX_SHIFT) * num;
    s   = 0;
    for (int k = 1; k <= MAX_SHIFT; k++)
      if (longint'(k) * den <= lim) s = k;
    return s;
  endfunction

  function automatic void queue_shifted(input int x, input int right_col, input int w,
                                        input int h, input bit last, input bit done);
    shifted_px_t px;
    int          s, rc, bc;
    s  = radial_shift(x, row_pos, w, h);
    rc = (x + s > right_col) ? right_col : x + s;
    bc = (x >= s) ? x - s : 0;
    px.blue  = line_win[bc % WIN_DEPTH].blue;
    px.green = line_win[x % WIN_DEPTH].green;
    px.red   = line_win[rc % WIN_DEPTH].red;
    px.last  = last;
    px.done  = done;
    shifted_due.push_back(px);
  endfunction

  // Advance the predictor by one accepted pixel; returns the number of outputs it causes
  function automatic int aberrate(input rca_pixel_t p);
    int w, h, c, n;
    bit frame_end;
    w = clamp_dim(width_reg, MIN_WIDTH);
    h = clamp_dim(height_reg, 1);
    c = col_pos;
    n = 0;
    line_win[c % WIN_DEPTH] = p;
    if (c >= w - 1) begin
      frame_end = (row_pos >= h - 1);
      for (int x = c - MAX_SHIFT; x <= c; x++) begin
        queue_shifted(x, c, w, h, x == c, (x == c) && frame_end);
        n++;
      end
      col_pos = 0;
      rows_ended++;
      if (frame_end) begin
        row_pos = 0;
        frames_ended++;
      end else begin
        row_pos++;
      end
    end else begin
      if (c >= MAX_SHIFT) begin
        queue_shifted(c - MAX_SHIFT, c, w, h, 1'b1, 1'b0);
        n = 1;
      end
      col_pos = c + 1;
    end
    return n;
  endfunction

  function automatic int gap_draw();
    int g;
    g = 0;
    if (in_steady) return 0;
    while ($urandom_range(99) < 32) g++;
    return g;
  endfunction

  function automatic rca_pixel_t random_pixel();
    rca_pixel_t p;
    p = rca_pixel_t'(24'($urandom));
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(input rca_pixel_t p, output int caused);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= p.red;
    in_green <= p.green;
    in_blue  <= p.blue;
    do @(posedge clk); while (in_stall);
    caused = aberrate(p);
    pixels_sent++;
  endtask

  // Hold the input until every predicted output has come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shifted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // Output side: random stall, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_stall <= !out_steady && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    shifted_px_t want;
    if (!rst && out_valid && !out_stall) begin
      if (shifted_due.size() == 0) begin
        report_fault($sformatf("output request with nothing expected: b%h g%h r%h l%b f%b",
                               out_blue, out_green, out_red, last_of_run, frame_done));
      end else begin
        want = shifted_due.pop_front();
        if (out_blue !== want.blue || out_green !== want.green || out_red !== want.red ||
            last_of_run !== want.last || frame_done !== want.done)
          report_fault($sformatf("output %0d: got b%h g%h r%h l%b f%b, want b%h g%h r%h l%b f%b",
                                 results_seen, out_blue, out_green, out_red, last_of_run,
                                 frame_done, want.blue, want.green, want.red, want.last,
                                 want.done));
      end
      results_seen++;
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int               caused, phase, w_eff, n;
    logic [CFG_W-1:0] wv, hv;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_blue   <= '0;
    in_green  <= '0;
    in_red    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_pixel(directed_rows[i].pix, caused);
        if (caused != directed_rows[i].exp_n)
          report_fault($sformatf("directed pixel %0d caused %0d outputs, table says %0d",
                                 i, caused, directed_rows[i].exp_n));
      end
    end

    // Random phases: mostly whole rows at small widths, with odd geometry now and then
    phase = 0;
    while (pixels_sent < TOTAL_PIXELS || phase < 3) begin
      case ($urandom_range(9))
        0:       wv = CFG_W'($urandom_range(0, MIN_WIDTH - 1));
        1:       wv = CFG_W'($urandom_range(MAX_DIM, 8191));
        default: wv = CFG_W'($urandom_range(MIN_WIDTH, MIN_WIDTH + 8));
      endcase
      case ($urandom_range(9))
        0:       hv = '0;
        1:       hv = CFG_W'($urandom_range(MAX_DIM, 8191));
        default: hv = CFG_W'($urandom_range(1, 4));
      endcase
      if (phase == 1 || $urandom_range(3) != 0) write_reg(REG_IMAGE_WIDTH, wv);
      if ($urandom_range(3) != 0) write_reg(REG_IMAGE_HEIGHT, hv);
      w_eff      = clamp_dim(width_reg, MIN_WIDTH);
      in_steady  = (phase == 1 || phase == 2);
      out_steady = (phase == 2);
      // Block the output for a long stretch while pixels keep coming
      if (phase == 1) hold_out = 1'b1;
      if (w_eff > 64)
        n = $urandom_range(MIN_WIDTH, MIN_WIDTH + 8);
      else if (phase != 1 && $urandom_range(4) == 0)
        n = $urandom_range(1, w_eff);
      else
        n = ((col_pos >= w_eff) ? 1 : w_eff - col_pos) + w_eff * $urandom_range(0, 1);
      repeat (n) send_pixel(random_pixel(), caused);
      phase++;
    end

    in_valid <= 1'b0;
    while (shifted_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d pixels in %0d random phases; checked %0d shifted outputs.",
             pixels_sent, phase, results_seen);
    $display("Rows completed: %0d, frames completed: %0d.", rows_ended, frames_ended);
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
